>>> rtl/core/ipth_pkg.sv
// Shared types, protocol codes and port service tables for the IPv4 TCP/UDP
// header parser. Used by ipth_capture, ipth_record and the top level.
// No dependencies.
package ipth_pkg;

  localparam logic [6:0] LINK_ETH_BYTES = 7'd14;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [3:0] IP_VERSION_4 = 4'd4;

  localparam logic [2:0] CLASS_OTHER = 3'd0;
  localparam logic [2:0] CLASS_TCP   = 3'd1;
  localparam logic [2:0] CLASS_UDP   = 3'd2;
  localparam logic [2:0] CLASS_ICMP  = 3'd3;
  localparam logic [2:0] CLASS_IGMP  = 3'd4;

  localparam logic [4:0] SVC_UNKNOWN = 5'd0;
  localparam logic [4:0] SVC_MAX     = 5'd27;

  // TCP header flag bits in the low flags byte.
  localparam int TCP_FIN_BIT = 0;
  localparam int TCP_SYN_BIT = 1;
  localparam int TCP_RST_BIT = 2;
  localparam int TCP_PSH_BIT = 3;
  localparam int TCP_ACK_BIT = 4;

  // Header fields captured from one frame, handed over on its last byte.
  typedef struct packed {
    logic        mac_en;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [7:0]  version_ihl;
    logic [15:0] total_length;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] ports;
    logic [15:0] udp_length;
    logic [15:0] tcp_offset_flags;
  } frame_t;

  // One result record.
  typedef struct packed {
    logic        is_ipv4;
    logic [31:0] packet_number;
    logic [2:0]  proto_class;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] length_value;
    logic [4:0]  tcp_flag_bits;
    logic [4:0]  service_code;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
  } rec_t;

  function automatic logic [4:0] tcp_service(input logic [15:0] port);
    logic [4:0] code;
    unique case (port)
      16'd20:  code = 5'd1;
      16'd21:  code = 5'd2;
      16'd22:  code = 5'd3;
      16'd23:  code = 5'd4;
      16'd25:  code = 5'd5;
      16'd53:  code = 5'd6;
      16'd80:  code = 5'd7;
      16'd110: code = 5'd8;
      16'd143: code = 5'd9;
      16'd179: code = 5'd10;
      16'd389: code = 5'd11;
      16'd443: code = 5'd12;
      16'd445: code = 5'd13;
      16'd587: code = 5'd14;
      16'd636: code = 5'd15;
      16'd993: code = 5'd16;
      default: code = SVC_UNKNOWN;
    endcase
    return code;
  endfunction

  // UDP codes follow the TCP codes, so the first UDP entry is 17.
  function automatic logic [4:0] udp_service(input logic [15:0] port);
    logic [4:0] code;
    unique case (port)
      16'd22:  code = 5'd17;
      16'd53:  code = 5'd18;
      16'd67:  code = 5'd19;
      16'd68:  code = 5'd20;
      16'd69:  code = 5'd21;
      16'd123: code = 5'd22;
      16'd161: code = 5'd23;
      16'd389: code = 5'd24;
      16'd443: code = 5'd25;
      16'd514: code = 5'd26;
      16'd636: code = 5'd27;
      default: code = SVC_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/core/ipth_capture.sv
// Byte capture stage: tracks the offset in the frame and loads each header
// byte into its field. Depends on ipth_pkg.
module ipth_capture (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_valid,
  output logic            byte_ready,
  input  logic [7:0]      frame_byte,
  input  logic            last_byte,
  input  logic [6:0]      link_hdr,
  output logic            snap_valid,
  input  logic            snap_ready,
  output ipth_pkg::frame_t snap
);
  import ipth_pkg::*;

  logic        accept;
  logic [15:0] off_r;
  logic [47:0] dmac_r, dmac_nxt;
  logic [47:0] smac_r, smac_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] sip_r, sip_nxt;
  logic [31:0] dip_r, dip_nxt;
  logic [31:0] ports_r, ports_nxt;
  logic [15:0] ulen_r, ulen_nxt;
  logic [15:0] tof_r, tof_nxt;
  logic [15:0] base_ip;
  logic [15:0] base_tp;
  logic        snap_valid_r;
  frame_t      snap_r;

  assign accept     = byte_valid && byte_ready;
  assign byte_ready = !snap_valid_r || snap_ready;
  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  always_comb begin
    dmac_nxt  = dmac_r;
    smac_nxt  = smac_r;
    ver_nxt   = ver_r;
    tlen_nxt  = tlen_r;
    proto_nxt = proto_r;
    sip_nxt   = sip_r;
    dip_nxt   = dip_r;
    ports_nxt = ports_r;
    ulen_nxt  = ulen_r;
    tof_nxt   = tof_r;
    base_ip   = {9'd0, link_hdr};

    // Fields are big endian: the first byte on the wire is the top byte.
    for (int j = 0; j < 6; j++) begin
      if (off_r == 16'(j))     dmac_nxt[8*(5-j) +: 8] = frame_byte;
      if (off_r == 16'(6 + j)) smac_nxt[8*(5-j) +: 8] = frame_byte;
    end
    if (off_r == base_ip) ver_nxt = frame_byte;
    for (int j = 0; j < 2; j++) begin
      if (off_r == base_ip + 16'(2 + j)) tlen_nxt[8*(1-j) +: 8] = frame_byte;
    end
    if (off_r == base_ip + 16'd9) proto_nxt = frame_byte;
    for (int j = 0; j < 4; j++) begin
      if (off_r == base_ip + 16'(12 + j)) sip_nxt[8*(3-j) +: 8] = frame_byte;
      if (off_r == base_ip + 16'(16 + j)) dip_nxt[8*(3-j) +: 8] = frame_byte;
    end

    // The transport header starts after the IPv4 header length, which may
    // have arrived in this very byte.
    base_tp = base_ip + {10'd0, ver_nxt[3:0], 2'b00};
    for (int j = 0; j < 4; j++) begin
      if (off_r == base_tp + 16'(j)) ports_nxt[8*(3-j) +: 8] = frame_byte;
    end
    for (int j = 0; j < 2; j++) begin
      if (off_r == base_tp + 16'(4 + j))  ulen_nxt[8*(1-j) +: 8] = frame_byte;
      if (off_r == base_tp + 16'(12 + j)) tof_nxt[8*(1-j) +: 8]  = frame_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      dmac_r  <= '0;
      smac_r  <= '0;
      ver_r   <= '0;
      tlen_r  <= '0;
      proto_r <= '0;
      sip_r   <= '0;
      dip_r   <= '0;
      ports_r <= '0;
      ulen_r  <= '0;
      tof_r   <= '0;
    end else if (accept) begin
      if (last_byte) begin
        off_r   <= '0;
        dmac_r  <= '0;
        smac_r  <= '0;
        ver_r   <= '0;
        tlen_r  <= '0;
        proto_r <= '0;
        sip_r   <= '0;
        dip_r   <= '0;
        ports_r <= '0;
        ulen_r  <= '0;
        tof_r   <= '0;
      end else begin
        if (off_r != 16'hFFFF) off_r <= off_r + 16'd1;
        dmac_r  <= dmac_nxt;
        smac_r  <= smac_nxt;
        ver_r   <= ver_nxt;
        tlen_r  <= tlen_nxt;
        proto_r <= proto_nxt;
        sip_r   <= sip_nxt;
        dip_r   <= dip_nxt;
        ports_r <= ports_nxt;
        ulen_r  <= ulen_nxt;
        tof_r   <= tof_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (accept && last_byte) begin
      snap_valid_r <= 1'b1;
    end else if (snap_ready) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      snap_r.mac_en           <= (link_hdr == LINK_ETH_BYTES);
      snap_r.dest_mac         <= dmac_nxt;
      snap_r.source_mac       <= smac_nxt;
      snap_r.version_ihl      <= ver_nxt;
      snap_r.total_length     <= tlen_nxt;
      snap_r.protocol         <= proto_nxt;
      snap_r.src_ip           <= sip_nxt;
      snap_r.dst_ip           <= dip_nxt;
      snap_r.ports            <= ports_nxt;
      snap_r.udp_length       <= ulen_nxt;
      snap_r.tcp_offset_flags <= tof_nxt;
    end
  end

  // A frame always starts again at offset zero after its last byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> off_r == 16'd0 && ver_r == 8'd0)
    else $error("frame state not cleared after last byte");

endmodule

>>> rtl/core/ipth_record.sv
// Record stage: classifies the captured header, computes payload length,
// flags and service code, numbers IPv4 packets and holds the result register.
// Depends on ipth_pkg.
module ipth_record #(
  parameter int COUNTER_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             snap_valid,
  output logic             snap_ready,
  input  ipth_pkg::frame_t snap,
  output logic             rec_valid,
  input  logic             rec_ready,
  output ipth_pkg::rec_t   rec
);
  import ipth_pkg::*;

  logic                    snap_move;
  logic [COUNTER_BITS-1:0] cnt_r;
  logic                    rec_valid_r;
  rec_t                    rec_r, rec_nxt;
  logic                    ipv4;
  logic [15:0]             sport, dport;
  logic [15:0]             hdr_len;
  logic [15:0]             tcp_len;
  logic [7:0]              fl;
  logic [4:0]              tcp_flags;
  logic [4:0]              svc_tcp, svc_udp;

  assign snap_ready = !rec_valid_r || rec_ready;
  assign snap_move  = snap_valid && snap_ready;
  assign rec_valid  = rec_valid_r;
  assign rec        = rec_r;

  always_comb begin
    ipv4    = (snap.version_ihl[7:4] == IP_VERSION_4);
    sport   = snap.ports[31:16];
    dport   = snap.ports[15:0];
    hdr_len = {10'd0, snap.version_ihl[3:0], 2'b00} +
              {10'd0, snap.tcp_offset_flags[15:12], 2'b00};
    tcp_len = (snap.total_length > hdr_len) ? snap.total_length - hdr_len : 16'd0;
    fl      = snap.tcp_offset_flags[7:0];
    tcp_flags = {fl[TCP_RST_BIT], fl[TCP_PSH_BIT], fl[TCP_FIN_BIT],
                 fl[TCP_ACK_BIT], fl[TCP_SYN_BIT]};
    // The source port wins when both ports are known services.
    svc_tcp = (tcp_service(sport) != SVC_UNKNOWN) ? tcp_service(sport) : tcp_service(dport);
    svc_udp = (udp_service(sport) != SVC_UNKNOWN) ? udp_service(sport) : udp_service(dport);

    rec_nxt            = '0;
    rec_nxt.dest_mac   = snap.mac_en ? snap.dest_mac : 48'd0;
    rec_nxt.source_mac = snap.mac_en ? snap.source_mac : 48'd0;
    if (ipv4) begin
      rec_nxt.is_ipv4       = 1'b1;
      rec_nxt.packet_number = 32'(cnt_r);
      rec_nxt.source_ip     = snap.src_ip;
      rec_nxt.dest_ip       = snap.dst_ip;
      case (snap.protocol)
        PROTO_TCP: begin
          rec_nxt.proto_class   = CLASS_TCP;
          rec_nxt.source_port   = sport;
          rec_nxt.dest_port     = dport;
          rec_nxt.length_value  = tcp_len;
          rec_nxt.tcp_flag_bits = tcp_flags;
          rec_nxt.service_code  = svc_tcp;
        end
        PROTO_UDP: begin
          rec_nxt.proto_class  = CLASS_UDP;
          rec_nxt.source_port  = sport;
          rec_nxt.dest_port    = dport;
          rec_nxt.length_value = snap.udp_length;
          rec_nxt.service_code = svc_udp;
        end
        PROTO_ICMP: rec_nxt.proto_class = CLASS_ICMP;
        PROTO_IGMP: rec_nxt.proto_class = CLASS_IGMP;
        default:    rec_nxt.proto_class = CLASS_OTHER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
      cnt_r       <= COUNTER_BITS'(1);
    end else begin
      if (snap_move) begin
        rec_valid_r <= 1'b1;
      end else if (rec_ready) begin
        rec_valid_r <= 1'b0;
      end
      if (snap_move && ipv4) cnt_r <= cnt_r + COUNTER_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (snap_move) rec_r <= rec_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !(snap_move && ipv4) |=> $stable(cnt_r))
    else $error("packet counter moved without an IPv4 record");

  assert property (@(posedge clk) disable iff (!rst_n)
    rec_valid_r && !rec_r.is_ipv4 |->
      rec_r.packet_number == 32'd0 && rec_r.proto_class == CLASS_OTHER &&
      rec_r.source_ip == 32'd0 && rec_r.length_value == 16'd0)
    else $error("non-IPv4 record carries IP fields");

  assert property (@(posedge clk) disable iff (!rst_n)
    rec_valid_r && rec_r.proto_class != CLASS_TCP |-> rec_r.tcp_flag_bits == 5'd0)
    else $error("TCP flags on a non-TCP record");

  assert property (@(posedge clk) disable iff (!rst_n)
    rec_valid_r |-> rec_r.service_code <= SVC_MAX &&
      (rec_r.proto_class == CLASS_TCP || rec_r.proto_class == CLASS_UDP ||
       rec_r.service_code == SVC_UNKNOWN))
    else $error("service code out of range for protocol class");

endmodule

>>> rtl/core/ipv4_tcp_udp_header_parser_unit.sv
// IPv4 TCP/UDP header parser, top level: configuration register, byte
// capture stage and record stage. Depends on ipth_pkg, ipth_capture and
// ipth_record.
//
// Usage:
//   The in_ channel takes one frame byte per transfer in wire order, with
//   in_tlast on the final captured byte. Each frame produces exactly one
//   record on the out_ channel, after its last byte; other bytes produce none.
//   The block takes one byte every cycle while in_tready is high. A record
//   passes through the capture register, then out_tvalid rises with the
//   result register. Frames may follow back to back, last byte after last
//   byte, one record per cycle while out_tready stays high.
//   cfg_wr_en writes the link header length; 14 selects Ethernet with MACs.
//   Write it only between frames, with no record pending.
//   Reset clears the frame state, sets the link header length to 14 and the
//   IPv4 packet number to one.
//   When the receiver holds out_tready low, the record waits in the result
//   register and one more frame can complete into the capture register; once
//   that frame is held, in_tready stays low for every byte until the receiver
//   takes the waiting record.
module ipv4_tcp_udp_header_parser_unit #(
  parameter int COUNTER_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [6:0]   cfg_wr_data,    // link_header_bytes
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,       // [7:0] frame_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata,      // packet_number, source_ip, dest_ip,
                                       // source_port, dest_port, length_value,
                                       // tcp_flag_bits, service_code,
                                       // dest_mac, source_mac, zero pad
  output logic [3:0]   out_tuser       // is_ipv4, proto_class
);
  import ipth_pkg::*;

  logic [6:0] link_hdr_r;
  logic       snap_valid;
  logic       snap_ready;
  frame_t     snap;
  rec_t       rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_hdr_r <= LINK_ETH_BYTES;
    end else if (cfg_wr_en) begin
      link_hdr_r <= cfg_wr_data;
    end
  end

  ipth_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_ready (in_tready),
    .frame_byte (in_tdata),
    .last_byte  (in_tlast),
    .link_hdr   (link_hdr_r),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  ipth_record #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_record (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .rec_valid  (out_tvalid),
    .rec_ready  (out_tready),
    .rec        (rec)
  );

  assign out_tdata = {6'd0, rec.source_mac, rec.dest_mac, rec.service_code,
                      rec.tcp_flag_bits, rec.length_value, rec.dest_port,
                      rec.source_port, rec.dest_ip, rec.source_ip,
                      rec.packet_number};
  assign out_tuser = {rec.proto_class, rec.is_ipv4};

endmodule

>>> bench/ipv4_tcp_udp_header_parser_unit_tb.sv
// Self-checking testbench for ipv4_tcp_udp_header_parser_unit: frames go in as byte
// streams and each record that comes out is checked against a behavioral parser model.
// Depends on ipth_pkg and the parser RTL.
`timescale 1ns / 100ps

module ipv4_tcp_udp_header_parser_unit_tb;
  import ipth_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES  = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic [6:0]   cfg_wr_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [255:0] out_tdata;
  logic [3:0]   out_tuser;

  ipv4_tcp_udp_header_parser_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // Stimulus and expectation stores.
  stream_byte_t pending_bytes[$];
  rec_t         expected_records[$];
  logic [7:0]   frame_buf[$];

  // Service port tables of the parser model, and the ports the stimulus favors.
  int tcp_ports[16] = '{20, 21, 22, 23, 25, 53, 80, 110, 143, 179, 389, 443, 445, 587,
                        636, 993};
  int udp_ports[11] = '{22, 53, 67, 68, 69, 123, 161, 389, 443, 514, 636};
  int known_ports[22] = '{20, 21, 22, 23, 25, 53, 67, 68, 69, 80, 110, 123, 143, 161, 179,
                          389, 443, 445, 514, 587, 636, 993};

  // Parser model state.
  int          link_bytes;
  int          frame_pos;
  logic [47:0] mac_dst, mac_src;
  logic [7:0]  ver_ihl;
  logic [15:0] ip_total_len;
  logic [7:0]  ip_proto;
  logic [31:0] ip_src, ip_dst;
  logic [31:0] l4_ports;
  logic [15:0] udp_len;
  logic [15:0] tcp_off_flags;
  logic [31:0] ipv4_count;

  // Bookkeeping.
  int  error_count;
  int  cycle_count;
  int  byte_count;
  int  frame_count;
  int  records_seen;
  int  ipv4_seen;
  bit  byte_taken;
  bit  hold_request;
  int  hold_left;
  int  gap_left;
  int  burst_left;
  int  pattern_age;
  logic [15:0] ready_pattern;
  stream_byte_t next_byte;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("ipv4_tcp_udp_header_parser_unit verification failed");
      $finish;
    end
  end

  // Overwrite byte k (0 = most significant) of an n-byte field based at base.
  function automatic logic [63:0] merge_byte(input logic [63:0] cur, input int pos,
                                             input int base, input int n,
                                             input logic [7:0] b);
    int sh;
    if (pos < base || pos >= base + n) return cur;
    sh = 8 * (n - 1 - (pos - base));
    cur[sh +: 8] = b;
    return cur;
  endfunction

  // UDP codes start right after the sixteen TCP codes.
  function automatic logic [4:0] port_service(input logic [15:0] port, input bit is_udp);
    if (is_udp) begin
      for (int i = 0; i < 11; i++)
        if (udp_ports[i] == port) return 5'(i + 17);
    end else begin
      for (int i = 0; i < 16; i++)
        if (tcp_ports[i] == port) return 5'(i + 1);
    end
    return SVC_UNKNOWN;
  endfunction

  task automatic clear_frame_state();
    frame_pos     = 0;
    mac_dst       = '0;
    mac_src       = '0;
    ver_ihl       = '0;
    ip_total_len  = '0;
    ip_proto      = '0;
    ip_src        = '0;
    ip_dst        = '0;
    l4_ports      = '0;
    udp_len       = '0;
    tcp_off_flags = '0;
  endtask

  // Advance the parser model by one accepted byte; a last byte yields one record.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int          ihl_bytes;
    int          l4_base;
    int          hdr_bytes;
    logic [15:0] sport, dport;
    logic [7:0]  fl;
    rec_t        rec;
    mac_dst      = 48'(merge_byte(64'(mac_dst), frame_pos, 0, 6, b));
    mac_src      = 48'(merge_byte(64'(mac_src), frame_pos, 6, 6, b));
    ver_ihl      = 8'(merge_byte(64'(ver_ihl), frame_pos, link_bytes, 1, b));
    ip_total_len = 16'(merge_byte(64'(ip_total_len), frame_pos, link_bytes + 2, 2, b));
    ip_proto     = 8'(merge_byte(64'(ip_proto), frame_pos, link_bytes + 9, 1, b));
    ip_src       = 32'(merge_byte(64'(ip_src), frame_pos, link_bytes + 12, 4, b));
    ip_dst       = 32'(merge_byte(64'(ip_dst), frame_pos, link_bytes + 16, 4, b));
    // The transport offset follows the header length as soon as its byte is in.
    ihl_bytes     = ver_ihl[3:0] * 4;
    l4_base       = link_bytes + ihl_bytes;
    l4_ports      = 32'(merge_byte(64'(l4_ports), frame_pos, l4_base, 4, b));
    udp_len       = 16'(merge_byte(64'(udp_len), frame_pos, l4_base + 4, 2, b));
    tcp_off_flags = 16'(merge_byte(64'(tcp_off_flags), frame_pos, l4_base + 12, 2, b));
    if (frame_pos < 16'hFFFF) frame_pos++;
    if (!last) return;

    rec = '0;
    if (link_bytes == LINK_ETH_BYTES) begin
      rec.dest_mac   = mac_dst;
      rec.source_mac = mac_src;
    end
    if (ver_ihl[7:4] == IP_VERSION_4) begin
      rec.is_ipv4       = 1'b1;
      rec.packet_number = ipv4_count;
      ipv4_count++;
      rec.source_ip = ip_src;
      rec.dest_ip   = ip_dst;
      sport = l4_ports[31:16];
      dport = l4_ports[15:0];
      case (ip_proto)
        PROTO_TCP: begin
          rec.proto_class = CLASS_TCP;
          hdr_bytes = ihl_bytes + tcp_off_flags[15:12] * 4;
          rec.length_value = (ip_total_len > hdr_bytes) ? 16'(ip_total_len - hdr_bytes) : '0;
          fl = tcp_off_flags[7:0];
          rec.tcp_flag_bits = {fl[TCP_RST_BIT], fl[TCP_PSH_BIT], fl[TCP_FIN_BIT],
                               fl[TCP_ACK_BIT], fl[TCP_SYN_BIT]};
          rec.service_code = port_service(sport, 1'b0);
          if (rec.service_code == SVC_UNKNOWN) rec.service_code = port_service(dport, 1'b0);
        end
        PROTO_UDP: begin
          rec.proto_class  = CLASS_UDP;
          rec.length_value = udp_len;
          rec.service_code = port_service(sport, 1'b1);
          if (rec.service_code == SVC_UNKNOWN) rec.service_code = port_service(dport, 1'b1);
        end
        PROTO_ICMP: rec.proto_class = CLASS_ICMP;
        PROTO_IGMP: rec.proto_class = CLASS_IGMP;
        default:    rec.proto_class = CLASS_OTHER;
      endcase
      if (rec.proto_class == CLASS_TCP || rec.proto_class == CLASS_UDP) begin
        rec.source_port = sport;
        rec.dest_port   = dport;
      end
    end
    expected_records.push_back(rec);
    clear_frame_state();
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      error_count++;
    end
  endtask

  task automatic check_record();
    rec_t got, want;
    got.is_ipv4       = out_tuser[0];
    got.proto_class   = out_tuser[3:1];
    got.packet_number = out_tdata[31:0];
    got.source_ip     = out_tdata[63:32];
    got.dest_ip       = out_tdata[95:64];
    got.source_port   = out_tdata[111:96];
    got.dest_port     = out_tdata[127:112];
    got.length_value  = out_tdata[143:128];
    got.tcp_flag_bits = out_tdata[148:144];
    got.service_code  = out_tdata[153:149];
    got.dest_mac      = out_tdata[201:154];
    got.source_mac    = out_tdata[249:202];
    records_seen++;
    if (got.is_ipv4) ipv4_seen++;
    if (expected_records.size() == 0) begin
      $display("%0t: unexpected record, expected none, actual %0h", $time, got);
      error_count++;
      return;
    end
    want = expected_records.pop_front();
    check_field("is_ipv4", 64'(want.is_ipv4), 64'(got.is_ipv4));
    check_field("packet_number", 64'(want.packet_number), 64'(got.packet_number));
    check_field("proto_class", 64'(want.proto_class), 64'(got.proto_class));
    check_field("source_ip", 64'(want.source_ip), 64'(got.source_ip));
    check_field("dest_ip", 64'(want.dest_ip), 64'(got.dest_ip));
    check_field("source_port", 64'(want.source_port), 64'(got.source_port));
    check_field("dest_port", 64'(want.dest_port), 64'(got.dest_port));
    check_field("length_value", 64'(want.length_value), 64'(got.length_value));
    check_field("tcp_flag_bits", 64'(want.tcp_flag_bits), 64'(got.tcp_flag_bits));
    check_field("service_code", 64'(want.service_code), 64'(got.service_code));
    check_field("dest_mac", 64'(want.dest_mac), 64'(got.dest_mac));
    check_field("source_mac", 64'(want.source_mac), 64'(got.source_mac));
  endtask

  // Monitor: records are checked before the byte of the same edge is modeled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_record();
      if (in_tvalid && in_tready) begin
        byte_taken = 1'b1;
        parse_byte(in_tdata, in_tlast);
      end
    end
  end

  // Driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!in_tvalid || byte_taken) begin
      byte_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
      end else if (pending_bytes.size() > 0) begin
        next_byte = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_byte.data;
        in_tlast  <= next_byte.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 8) : 0;
        end
      end else begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
      end
    end
  end

  // Receiver: a rotating ready pattern, refreshed now and then, plus long hold-offs.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      pattern_age++;
      if (pattern_age >= 64) begin
        pattern_age   = 0;
        ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end
      ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
      out_tready <= ready_pattern[0];
    end
  end

  task automatic commit_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      pending_bytes.push_back('{data: frame_buf[i], last: (i == frame_buf.size() - 1)});
    byte_count += frame_buf.size();
    frame_count++;
  endtask

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 3))
      0, 1:    return 16'(known_ports[$urandom_range(0, 21)]);
      2:       return 16'($urandom);
      default: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // Builds one random frame for the given link header length. Most frames are
  // well-formed IPv4; some are noise, carry another version, or are cut short.
  task automatic queue_frame(input int link_len);
    int          kind, ihl, l4_off, l4_len, total, cut, ver;
    logic [7:0]  proto;
    logic [15:0] tl, sport, dport, ulen;
    logic [3:0]  data_off;
    frame_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      total = $urandom_range(1, 40);
      repeat (total) frame_buf.push_back(8'($urandom));
    end else begin
      ihl = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
      case ($urandom_range(0, 5))
        0, 1:    proto = PROTO_TCP;
        2, 3:    proto = PROTO_UDP;
        4:       proto = ($urandom_range(0, 1) == 1) ? PROTO_ICMP : PROTO_IGMP;
        default: proto = 8'($urandom);
      endcase
      l4_len = (proto == PROTO_TCP) ? 20 : 8;
      l4_off = link_len + ihl * 4;
      total  = (link_len + 20 > l4_off + l4_len) ? link_len + 20 : l4_off + l4_len;
      total += $urandom_range(0, 12);
      repeat (total) frame_buf.push_back(8'($urandom));
      if ($urandom_range(0, 7) == 0)
        for (int i = 0; i < link_len && i < 12; i++)
          frame_buf[i] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;

      // Transport fields go in first so that a short IPv4 header overlays them.
      sport = pick_port();
      dport = pick_port();
      frame_buf[l4_off]     = sport[15:8];
      frame_buf[l4_off + 1] = sport[7:0];
      frame_buf[l4_off + 2] = dport[15:8];
      frame_buf[l4_off + 3] = dport[7:0];
      if (proto == PROTO_TCP) begin
        data_off = ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom);
        frame_buf[l4_off + 12] = {data_off, 4'($urandom)};
      end else begin
        ulen = ($urandom_range(0, 1) == 1) ? 16'(total - l4_off) : 16'($urandom);
        frame_buf[l4_off + 4] = ulen[15:8];
        frame_buf[l4_off + 5] = ulen[7:0];
      end

      ver = IP_VERSION_4;
      if (kind == 1) begin
        ver = $urandom_range(0, 14);
        if (ver >= IP_VERSION_4) ver++;
      end
      frame_buf[link_len] = {4'(ver), 4'(ihl)};
      tl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(total - link_len);
      frame_buf[link_len + 2] = tl[15:8];
      frame_buf[link_len + 3] = tl[7:0];
      frame_buf[link_len + 9] = proto;

      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, total);
        while (frame_buf.size() > cut) frame_buf.delete(frame_buf.size() - 1);
      end
    end
    commit_frame();
  endtask

  task automatic write_link_len(input int value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 7'(value);
    link_bytes = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  int link_plan[NUM_PHASES];
  int phase_start_bytes, phase_start_frames;

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    byte_count   = 0;
    frame_count  = 0;
    records_seen = 0;
    ipv4_seen    = 0;
    byte_taken   = 1'b0;
    hold_request = 1'b0;
    hold_left    = 0;
    gap_left     = 0;
    burst_left   = 0;
    pattern_age  = 0;
    ready_pattern = 16'hFFFF;
    link_bytes   = LINK_ETH_BYTES;
    ipv4_count   = 32'd1;
    clear_frame_state();
    link_plan = '{LINK_ETH_BYTES, 0, 64, 3, LINK_ETH_BYTES, 63, 9, 0};
    link_plan[NUM_PHASES - 1] = $urandom_range(0, 64);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // The first phase runs on the reset value of the link header length.
      if (p > 0) write_link_len(link_plan[p]);
      @(posedge clk);
      phase_start_bytes  = byte_count;
      phase_start_frames = frame_count;
      if (p == 0) begin
        // Single-byte frames with all-ones and all-zero data.
        frame_buf = '{8'hFF};
        commit_frame();
        frame_buf = '{8'h00};
        commit_frame();
      end else if (p == 1) begin
        // No link header: a one-byte IPv4 frame, then a header length of zero so
        // that the ports and TCP offset overlay the IPv4 fields and the payload
        // size clamps at zero.
        frame_buf = '{8'h4F};
        commit_frame();
        frame_buf = '{8'h40, 8'h00, 8'h00, 8'h30, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'h40,
                      PROTO_TCP, 8'h12, 8'h34, 8'hF0, 8'h1F};
        commit_frame();
      end
      if (p == 2 || p == 5) hold_request = 1'b1;
      while (byte_count - phase_start_bytes < 140 || frame_count - phase_start_frames < 3)
        queue_frame(link_bytes);
      while (pending_bytes.size() != 0 || in_tvalid || expected_records.size() != 0)
        @(posedge clk);
      repeat (4) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d frames (%0d bytes) over %0d link header lengths; %0d records, %0d IPv4.",
             frame_count, byte_count, NUM_PHASES, records_seen, ipv4_seen);
    if (error_count == 0) begin
      $display("ipv4_tcp_udp_header_parser_unit verification clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("ipv4_tcp_udp_header_parser_unit verification failed");
    end
    $finish;
  end

endmodule
